FILE: rtl/pgma_pkg.sv
package pgma_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam int SQRT_BITS    = 17;
  localparam logic [14:0] PHI_RIGHT = 15'd11520;
  localparam logic [14:0] PHI_HALF  = 15'd23040;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic [11:0]       row;
    logic [9:0]        col;
    logic              last;
    logic              fend;
  } job_t;

  typedef struct packed {
    logic               valid;
    logic signed [26:0] x;
    logic signed [26:0] y;
    logic signed [24:0] z;
    logic [31:0]        s;
    logic [16:0]        m;
    logic [33:0]        m2;
    logic               x_zero;
    logic               y_zero;
    logic               flip;
    logic [11:0]        row;
    logic [9:0]         col;
    logic               last;
    logic               fend;
  } cell_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [22:0] atan_q16(input int i);
    logic [22:0] v;
    case (i)
      0:  v = 23'd2949120;
      1:  v = 23'd1740967;
      2:  v = 23'd919879;
      3:  v = 23'd466945;
      4:  v = 23'd234379;
      5:  v = 23'd117304;
      6:  v = 23'd58666;
      7:  v = 23'd29335;
      8:  v = 23'd14668;
      9:  v = 23'd7334;
      10: v = 23'd3667;
      11: v = 23'd1833;
      12: v = 23'd917;
      13: v = 23'd458;
      14: v = 23'd229;
      15: v = 23'd115;
      16: v = 23'd57;
      17: v = 23'd29;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/pgma_ram.sv
module pgma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pgma_front.sv
module pgma_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,
  input  logic               en,
  output logic               job_valid,
  output pgma_pkg::job_t     job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = RW + 1;

  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [7:0] t0, m0, m1, b0, b1;
  logic [7:0] up, mid, p;
  pgma_pkg::job_t jobs [4];
  pgma_pkg::job_t nj [4];
  logic [2:0] cnt;
  logic [2:0] n_new;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [WW-1:0] w_last;
  logic [HW-1:0] h_last;
  logic accept, issue, cfg_wr, e1, e2, active;
  logic [31:0] fw32, fh32;

  assign p      = s_tdata;
  assign cfg_wr = cfg_valid && (cfg_index == pgma_pkg::REG_FRAME_WIDTH ||
                                cfg_index == pgma_pkg::REG_FRAME_HEIGHT);
  assign issue  = (cnt != 3'd0) && en;
  assign s_tready = (cnt == 3'd0) || (cnt == 3'd1 && en);
  assign accept = s_tvalid && s_tready;
  assign job_valid = (cnt != 3'd0);
  assign job = jobs[0];

  always_comb begin
    fw32 = 32'(frame_width);
    fh32 = 32'(frame_height);
    if (fw32 < 32'd2) begin
      w_eff = WW'(2);
    end else if (fw32 > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw32);
    end
    if (fh32 < 32'd2) begin
      h_eff = HW'(2);
    end else if (fh32 > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(fh32);
    end
    w_last = w_eff - WW'(1);
    h_last = h_eff - HW'(1);
  end

  assign e1 = ({1'b0, col} == w_last);
  assign e2 = ({1'b0, row} == h_last);
  assign active = (row != '0) && (col != '0);

  always_comb begin
    col_next = col;
    row_next = row;
    if (cfg_wr || rst) begin
      col_next = '0;
      row_next = '0;
    end else if (accept) begin
      if (e1) begin
        col_next = '0;
        row_next = e2 ? '0 : row + RW'(1);
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  pgma_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_older (
    .clk(clk), .we(accept), .waddr(col), .wdata(mid), .raddr(col_next), .rdata(up)
  );

  pgma_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_newer (
    .clk(clk), .we(accept), .waddr(col), .wdata(p), .raddr(col_next), .rdata(mid)
  );

  always_comb begin
    pgma_pkg::job_t j0, j1, j2, j3;
    logic [11:0] r1, hl;
    logic [9:0] c1, wl;
    r1 = 12'(row - RW'(1));
    c1 = 10'(col - CW'(1));
    hl = 12'(h_last);
    wl = 10'(w_last);
    j0.dx = $signed({1'b0, mid}) - $signed({1'b0, (col == CW'(1)) ? m0 : m1});
    j0.dy = $signed({1'b0, b0}) - $signed({1'b0, (row == RW'(1)) ? m0 : t0});
    j0.row = r1; j0.col = c1; j0.last = 1'b0; j0.fend = 1'b0;
    j1.dx = $signed({1'b0, mid}) - $signed({1'b0, m0});
    j1.dy = $signed({1'b0, p}) - $signed({1'b0, (row == RW'(1)) ? mid : up});
    j1.row = r1; j1.col = wl; j1.last = 1'b0; j1.fend = 1'b0;
    j2.dx = $signed({1'b0, p}) - $signed({1'b0, (col == CW'(1)) ? b0 : b1});
    j2.dy = $signed({1'b0, b0}) - $signed({1'b0, m0});
    j2.row = hl; j2.col = c1; j2.last = 1'b0; j2.fend = 1'b0;
    j3.dx = $signed({1'b0, p}) - $signed({1'b0, b0});
    j3.dy = $signed({1'b0, p}) - $signed({1'b0, mid});
    j3.row = hl; j3.col = wl; j3.last = 1'b0; j3.fend = 1'b1;
    nj[0] = j0;
    nj[1] = e1 ? j1 : j2;
    nj[2] = j2;
    nj[3] = j3;
    n_new = active ? 3'd1 + 3'(e1) + 3'(e2) + 3'(e1 && e2) : 3'd0;
    for (int k = 0; k < 4; k++) begin
      nj[k].last = (3'(k) == n_new - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd640;
      frame_height <= 13'd480;
      col <= '0;
      row <= '0;
      cnt <= 3'd0;
      t0 <= '0; m0 <= '0; m1 <= '0; b0 <= '0; b1 <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
      if (cfg_valid && cfg_index == pgma_pkg::REG_FRAME_WIDTH) begin
        frame_width <= cfg_data[10:0];
      end
      if (cfg_valid && cfg_index == pgma_pkg::REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end
      if (accept) begin
        t0 <= up;
        m1 <= m0;
        m0 <= mid;
        b1 <= b0;
        b0 <= p;
        cnt <= n_new;
      end else if (issue) begin
        cnt <= cnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      jobs <= nj;
    end else if (issue) begin
      jobs[0] <= jobs[1];
      jobs[1] <= jobs[2];
      jobs[2] <= jobs[3];
    end
  end

endmodule

FILE: rtl/pgma_cell.sv
module pgma_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  pgma_pkg::cell_t d,
  output pgma_pkg::cell_t q
);

  localparam int B = pgma_pkg::SQRT_BITS - 1 - IDX;

  pgma_pkg::cell_t n;
  logic signed [26:0] xs, ys;
  logic signed [24:0] a;

  assign xs = d.x >>> IDX;
  assign ys = d.y >>> IDX;
  assign a  = $signed({2'b00, pgma_pkg::atan_q16(IDX)});

  always_comb begin
    n = d;
    if (!d.y[26]) begin
      n.x = d.x + ys;
      n.y = d.y - xs;
      n.z = d.z + a;
    end else begin
      n.x = d.x - ys;
      n.y = d.y + xs;
      n.z = d.z - a;
    end
    if (B >= 0) begin
      logic [33:0] t2;
      t2 = d.m2 + (34'(d.m) << (B + 1)) + (34'd1 << (2 * B));
      if (t2 <= 34'(d.s)) begin
        n.m  = d.m | (17'd1 << B);
        n.m2 = t2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.x <= n.x; q.y <= n.y; q.z <= n.z; q.s <= n.s; q.m <= n.m; q.m2 <= n.m2;
      q.x_zero <= n.x_zero; q.y_zero <= n.y_zero; q.flip <= n.flip;
      q.row <= n.row; q.col <= n.col; q.last <= n.last; q.fend <= n.fend;
    end
  end

endmodule

FILE: rtl/pixel_gradient_magnitude_angle_unit.sv
// gradient magnitude and orientation of a grey pixel stream
// s_* carries one 8-bit pixel per beat in raster order; the frame wraps after
// frame_width * frame_height pixels, clamped to 2..MAX_WIDTH and 2..MAX_HEIGHT.
// cfg_* writes them (index 0 and 1), always ready; such a write restarts the frame.
// each pixel (r,c) with r,c >= 1 yields 1 to 4 result beats on m_*: the
// result for (r-1,c-1), plus the last column and last row flushed with it.
// m_tlast marks the last beat of one pixel, m_tuser the bottom-right pixel.
// a pixel is taken every cycle while it yields at most one beat and m_tready
// does not stall; a pixel with more beats holds the input until its jobs have
// issued one by one into the cell row. from pixel to its first beat the path
// runs through the job register, 18 cordic/sqrt cells and the output register.
// each cell does one vectoring rotation, the first 17 also one square-root bit.
// reset clears counters, window and pipeline valid bits; the row stores are
// not cleared. a stall on m_tready freezes the whole cell row and then the
// input once a job is waiting in the queue.
module pixel_gradient_magnitude_angle_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // pixel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // magnitude, angle, out_row, out_col, zero fill
  output logic        m_tlast,
  output logic        m_tuser    // frame_end
);

  localparam int N = pgma_pkg::CORDIC_STEPS;

  logic en, job_valid;
  pgma_pkg::job_t job;
  pgma_pkg::cell_t stg [N+1];
  logic [7:0] ax, ay;
  logic [16:0] sq;
  logic [15:0] mag;
  logic [14:0] ang, phi;
  logic signed [24:0] zc;
  logic [15:0] phi_raw;
  logic [33:0] rnd;
  pgma_pkg::cell_t f;

  assign cfg_ready = 1'b1;
  assign en = !m_tvalid || m_tready;

  pgma_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .en(en), .job_valid(job_valid), .job(job)
  );

  always_comb begin
    ax = 8'(job.dx[8] ? -job.dx : job.dx);
    ay = 8'(job.dy[8] ? -job.dy : job.dy);
    sq = 17'({8'h00, ax} * {8'h00, ax}) + 17'({8'h00, ay} * {8'h00, ay});
    stg[0].valid  = job_valid;
    stg[0].x      = $signed({3'b000, ax, 16'h0000});
    stg[0].y      = $signed({3'b000, ay, 16'h0000});
    stg[0].z      = '0;
    stg[0].s      = 32'(sq) << 14;
    stg[0].m      = '0;
    stg[0].m2     = '0;
    stg[0].x_zero = (ax == 8'd0);
    stg[0].y_zero = (ay == 8'd0);
    stg[0].flip   = (job.dx[8] && !job.dy[8]) ||
                    (job.dx != 9'sd0 && !job.dx[8] && job.dy[8]);
    stg[0].row    = job.row;
    stg[0].col    = job.col;
    stg[0].last   = job.last;
    stg[0].fend   = job.fend;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    pgma_cell #(.IDX(i)) u_cell (
      .clk(clk), .rst(rst), .en(en), .d(stg[i]), .q(stg[i+1])
    );
  end

  assign f = stg[N];

  always_comb begin
    zc = f.z[24] ? 25'sd0 : f.z;
    phi_raw = 16'((zc + 25'sd256) >>> 9);
    if (f.y_zero) begin
      phi = 15'd0;
    end else if (f.x_zero) begin
      phi = pgma_pkg::PHI_RIGHT;
    end else if (phi_raw > 16'(pgma_pkg::PHI_RIGHT)) begin
      phi = pgma_pkg::PHI_RIGHT;
    end else begin
      phi = phi_raw[14:0];
    end
    if (f.x_zero && f.y_zero) begin
      ang = 15'd0;
    end else if (f.flip) begin
      ang = pgma_pkg::PHI_HALF - phi;
    end else begin
      ang = phi;
    end
    rnd = f.m2 + 34'(f.m);
    mag = 16'(f.m + 17'(34'(f.s) > rnd));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= f.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {3'b000, f.col, f.row, ang, mag};
      m_tlast <= f.last;
      m_tuser <= f.fend;
    end
  end

endmodule

FILE: bench/pixel_gradient_magnitude_angle_unit_test.sv
module pixel_gradient_magnitude_angle_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct {
    logic [15:0] mag;
    logic [14:0] ang;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
    logic        fend;
  } grad_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // pixel
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // magnitude, angle, out_row, out_col, zero fill
  logic        m_tlast;
  logic        m_tuser;   // frame_end

  pixel_gradient_magnitude_angle_unit DUT (.*);

  logic [7:0] pixel_q[$];
  grad_t      grad_q[$];
  bit         failed;
  int         cycles;

  // predictor state
  logic [7:0] older_row[0:1023];
  logic [7:0] newer_row[0:1023];
  logic [7:0] win[0:5];
  int         row_cnt, col_cnt, width_reg, height_reg;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] grad_mag(int dx, int dy);
    longint s, m, t;
    s = longint'(dx * dx + dy * dy) * 16384;
    m = 0;
    for (int b = 16; b >= 0; b--) begin
      t = m | (longint'(1) << b);
      if (t * t <= s) m = t;
    end
    if (s > m * m + m) m++;
    return m[15:0];
  endfunction

  function automatic logic [14:0] grad_ang(int dx, int dy);
    longint x, y, z, nx, phi;
    x = dx < 0 ? -dx : dx;
    y = dy < 0 ? -dy : dy;
    z = 0;
    if (x == 0 && y == 0) return 15'd0;
    if (y == 0) phi = 0;
    else if (x == 0) phi = pgma_pkg::PHI_RIGHT;
    else begin
      x = x * 65536;
      y = y * 65536;
      for (int i = 0; i < pgma_pkg::CORDIC_STEPS; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(pgma_pkg::atan_q16(i));
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(pgma_pkg::atan_q16(i));
        end
        x = nx;
      end
      if (z < 0) z = 0;
      phi = (z + 256) >>> 9;
      if (phi > pgma_pkg::PHI_RIGHT) phi = pgma_pkg::PHI_RIGHT;
    end
    if ((dx < 0 && dy >= 0) || (dx > 0 && dy < 0)) return pgma_pkg::PHI_HALF - 15'(phi);
    return 15'(phi);
  endfunction

  function automatic void add_grad(int x1, int x2, int y1, int y2, int r, int c, bit fend);
    grad_t g;
    g.mag = grad_mag(x2 - x1, y2 - y1);
    g.ang = grad_ang(x2 - x1, y2 - y1);
    g.row = 12'(r);
    g.col = 10'(c);
    g.last = 0;
    g.fend = fend;
    grad_q.push_back(g);
  endfunction

  function automatic void predict_pixel(int p);
    int w, h, r, c, up, mid, t0, m0, m1, b0, b1;
    w = width_reg < 2 ? 2 : (width_reg > 1024 ? 1024 : width_reg);
    h = height_reg < 2 ? 2 : (height_reg > 4096 ? 4096 : height_reg);
    if (col_cnt >= w) col_cnt = 0;
    if (row_cnt >= h) row_cnt = 0;
    r = row_cnt;
    c = col_cnt;
    t0 = win[0]; m0 = win[2]; m1 = win[3]; b0 = win[4]; b1 = win[5];
    up = older_row[c];
    mid = newer_row[c];
    if (r >= 1 && c >= 1) begin
      add_grad(c == 1 ? m0 : m1, mid, r == 1 ? m0 : t0, b0, r - 1, c - 1, 0);
      if (c == w - 1) add_grad(m0, mid, r == 1 ? mid : up, p, r - 1, w - 1, 0);
      if (r == h - 1) begin
        add_grad(c == 1 ? b0 : b1, p, m0, b0, h - 1, c - 1, 0);
        if (c == w - 1) add_grad(b0, p, mid, p, h - 1, w - 1, 1);
      end
      grad_q[grad_q.size() - 1].last = 1;
    end
    older_row[c] = 8'(mid);
    newer_row[c] = 8'(p);
    win[1] = win[0]; win[0] = 8'(up);
    win[3] = win[2]; win[2] = 8'(mid);
    win[5] = win[4]; win[4] = 8'(p);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endfunction

  // predict and check at the rising edge
  always @(posedge clk) begin
    grad_t g;
    logic [15:0] a_mag;
    logic [14:0] a_ang;
    logic [11:0] a_row;
    logic [9:0]  a_col;
    cycles <= cycles + 1;
    if (rst) begin
      row_cnt = 0; col_cnt = 0; width_reg = 640; height_reg = 480;
      for (int i = 0; i < 6; i++) win[i] = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pgma_pkg::REG_FRAME_WIDTH) begin
          width_reg = cfg_data[10:0]; row_cnt = 0; col_cnt = 0;
        end else if (cfg_index == pgma_pkg::REG_FRAME_HEIGHT) begin
          height_reg = cfg_data; row_cnt = 0; col_cnt = 0;
        end
      end
      if (s_tvalid && s_tready) predict_pixel(s_tdata);
      if (m_tvalid && m_tready) begin
        a_mag = m_tdata[15:0];
        a_ang = m_tdata[30:16];
        a_row = m_tdata[42:31];
        a_col = m_tdata[52:43];
        if (grad_q.size() == 0) begin
          $display("%0t unexpected beat: mag %0d ang %0d row %0d col %0d",
                   $realtime, a_mag, a_ang, a_row, a_col);
          failed = 1;
        end else begin
          g = grad_q.pop_front();
          if (a_mag !== g.mag || a_ang !== g.ang || a_row !== g.row || a_col !== g.col ||
              m_tlast !== g.last || m_tuser !== g.fend || m_tdata[55:53] !== 3'd0) begin
            $display("%0t mismatch exp mag %0d ang %0d row %0d col %0d last %0d fend %0d",
                     $realtime, g.mag, g.ang, g.row, g.col, g.last, g.fend);
            $display("%0t          act mag %0d ang %0d row %0d col %0d last %0d fend %0d",
                     $realtime, a_mag, a_ang, a_row, a_col, m_tlast, m_tuser);
            failed = 1;
          end
        end
      end
    end
  end

  // pixel driver, bursts and gaps
  int  burst_left, gap_left;
  bit  s_fired;
  always @(posedge clk) s_fired <= s_tvalid && s_tready;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      burst_left = 0;
      gap_left = 0;
    end else if (!s_tvalid || s_fired) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 0;
      end else if (pixel_q.size() == 0) begin
        s_tvalid <= 0;
      end else begin
        s_tvalid <= 1;
        s_tdata <= pixel_q.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else burst_left--;
      end
    end
  end

  // receiver stall pattern
  logic [15:0] stall_mask;
  always @(negedge clk) begin
    if (cycles % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_mask <= 16'hffff;
        1: stall_mask <= 16'(~($urandom_range(0, 65535) & $urandom_range(0, 65535)));
        2: stall_mask <= 16'(($urandom_range(0, 65535)));
        default: stall_mask <= 16'h00ff;
      endcase
    end
    m_tready <= rst ? 1'b0 : stall_mask[cycles % 16];
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || s_tvalid || grad_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_pixels(int n);
    int prev;
    int kind;
    prev = $urandom_range(0, 255);
    kind = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: prev = $urandom_range(0, 255);
        1: prev = $urandom_range(0, 1) ? 255 : 0;
        2: prev = (prev + $urandom_range(0, 6)) & 8'hff;
        default: prev = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                        : (i * 37 + prev / 2) & 8'hff;
      endcase
      pixel_q.push_back(8'(prev));
    end
  endtask

  task automatic frame_phase(int w, int h, int n);
    drain();
    write_reg(pgma_pkg::REG_FRAME_WIDTH, 13'(w));
    write_reg(pgma_pkg::REG_FRAME_HEIGHT, 13'(h));
    random_pixels(n);
  endtask

  initial begin
    int w, h;
    logic [7:0] seq_a [16];
    logic [7:0] seq_b [8];
    failed = 0;
    cycles = 0;
    rst = 1;
    cfg_valid = 0;
    cfg_index = pgma_pkg::REG_FRAME_WIDTH;
    cfg_data = 0;
    s_tvalid = 0;
    s_tdata = 0;
    m_tready = 0;
    stall_mask = 16'hffff;
    seq_a = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255,
              8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0};
    seq_b = '{8'd10, 8'd200, 8'd255, 8'd1, 8'd128, 8'd127, 8'd0, 8'd64};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // smallest frame with extreme values, every flush case per pixel
    write_reg(pgma_pkg::REG_FRAME_WIDTH, 13'd2);
    write_reg(pgma_pkg::REG_FRAME_HEIGHT, 13'd2);
    foreach (seq_a[i]) pixel_q.push_back(seq_a[i]);
    // saturated low settings, ignored indexes
    drain();
    write_reg(pgma_pkg::REG_FRAME_WIDTH, 13'd0);
    write_reg(pgma_pkg::REG_FRAME_HEIGHT, 13'd1);
    write_reg(REG_SPARE_A, 13'h1fff);
    write_reg(REG_SPARE_B, 13'd5);
    foreach (seq_b[i]) pixel_q.push_back(seq_b[i]);

    frame_phase(3, 3, 30);
    frame_phase(13'h1fff, 3, 20);
    frame_phase(5, 13'h1fff, 40);
    frame_phase(2047, 4096, 20);
    for (int k = 0; k < 4; k++) begin
      w = $urandom_range(2, 6);
      h = $urandom_range(2, 4);
      frame_phase(w, h, w * h * $urandom_range(1, 2) + $urandom_range(0, 3));
    end
    frame_phase(640, 480, 20);
    drain();

    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/pgma_pkg.sv
rtl/pgma_ram.sv
rtl/pgma_front.sv
rtl/pgma_cell.sv
rtl/pixel_gradient_magnitude_angle_unit.sv
bench/pixel_gradient_magnitude_angle_unit_test.sv
